// ----- rtl/packet_header_classifier_keyword_assert.svh -----
// Assertion macros for the packet header classifier.
// Included by the modules that check their own logic; needs clk_i and rst_ni in scope.
`ifndef PACKET_HEADER_CLASSIFIER_KEYWORD_ASSERT_SVH
`define PACKET_HEADER_CLASSIFIER_KEYWORD_ASSERT_SVH

// Property checked on every rising clock edge while reset is released.
`define PHCK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define PHCK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/phck_pkg.sv -----
// Shared types, constants and helper functions of the packet header classifier.
// No dependencies.
`timescale 1ns / 1ps

package phck_pkg;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // UDP and ICMP headers have a fixed size.
  localparam logic [5:0] FIXED_TRANSPORT_BYTES = 6'd8;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_KEYWORD_BYTES  = 1'b0,
    CFG_KEYWORD_LENGTH = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    CLASS_TCP   = 2'd0,
    CLASS_UDP   = 2'd1,
    CLASS_ICMP  = 2'd2,
    CLASS_OTHER = 2'd3
  } proto_class_e;

  // One frame summary.
  typedef struct packed {
    logic               frame_accepted;
    logic               keyword_found;
    logic signed [16:0] payload_length;
    logic        [15:0] ip_total_length;
    logic               ports_present;
    logic        [15:0] dest_port;
    logic        [15:0] source_port;
    logic        [31:0] dest_address;
    logic        [31:0] source_address;
    proto_class_e       protocol_class;
  } summary_t;

  function automatic logic [5:0] transport_len(input logic [7:0] proto,
                                               input logic [5:0] tcp_bytes);
    return (proto == PROTO_TCP) ? tcp_bytes : FIXED_TRANSPORT_BYTES;
  endfunction

  // Payload size; -1 for an unknown protocol or a negative difference.
  function automatic logic signed [16:0] payload_len(input logic [7:0]  proto,
                                                     input logic [15:0] total,
                                                     input logic [5:0]  ip_bytes,
                                                     input logic [5:0]  tcp_bytes);
    logic [17:0] diff;
    logic        known;
    diff  = {2'b00, total} - {12'd0, ip_bytes} - {12'd0, transport_len(proto, tcp_bytes)};
    known = (proto == PROTO_TCP) || (proto == PROTO_UDP) || (proto == PROTO_ICMP);
    if (!known || diff[17]) begin
      return '1;
    end
    return diff[16:0];
  endfunction

  function automatic proto_class_e classify(input logic [7:0] proto);
    proto_class_e cls;
    case (proto)
      PROTO_TCP:  cls = CLASS_TCP;
      PROTO_UDP:  cls = CLASS_UDP;
      PROTO_ICMP: cls = CLASS_ICMP;
      default:    cls = CLASS_OTHER;
    endcase
    return cls;
  endfunction

endpackage

// ----- rtl/packet_header_classifier_keyword.sv -----
// Top level of the byte-serial IPv4/TCP/UDP header classifier with keyword match.
// Depends on phck_pkg and packet_header_classifier_keyword_assert.svh.
//
//   Channel   Dir  Handshake                     Payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tdata = frame_byte, tlast = frame_last
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata = summary fields, tuser = class
//   cfg       in   cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// One frame byte can be taken in every clock cycle; a byte waits only on a full result queue.
// The header fields, the payload window and the keyword compare are combinational from
// the per-frame registers, so the last byte's summary enters the queue as it is taken.
// A two-entry result queue holds summaries; input is stalled only while both entries wait.
// Reset (asynchronous, active low) clears the per-frame state, the keyword and the queue.
// Configuration writes are always taken and are meant to happen between frames.
`timescale 1ns / 1ps

`include "packet_header_classifier_keyword_assert.svh"

module packet_header_classifier_keyword #(
  parameter int KEY_MAX_BYTES     = 8,
  parameter int LINK_HEADER_BYTES = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Frame byte stream.
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,   // [7:0] frame_byte
  input  logic                     s_axis_tlast,   // frame_last
  // Frame summary stream.
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [31:0] source_address, [63:32] dest_address, [79:64] source_port,
  // [95:80] dest_port, [96] ports_present, [112:97] ip_total_length,
  // [129:113] payload_length, [130] keyword_found, [131] frame_accepted, [135:132] zero
  output logic [135:0]             m_axis_tdata,
  output phck_pkg::proto_class_e   m_axis_tuser,   // [1:0] protocol_class
  // Configuration writes.
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  phck_pkg::cfg_index_e     cfg_index_i,
  input  logic [63:0]              cfg_data_i
);

  import phck_pkg::*;

  localparam int WinW  = 8 * KEY_MAX_BYTES;
  localparam int SeenW = $clog2(KEY_MAX_BYTES + 1);
  localparam logic [15:0]      LinkOff = 16'(LINK_HEADER_BYTES);
  localparam logic [3:0]       KeyMax  = 4'(KEY_MAX_BYTES);
  localparam logic [SeenW-1:0] SeenMax = SeenW'(KEY_MAX_BYTES);

  // Configuration registers.
  logic [63:0] keyword_q;
  logic [3:0]  key_len_q;

  // Per-frame registers.
  logic [15:0]      byte_off_q, byte_off_d;
  logic [5:0]       ip_hdr_q, ip_hdr_d;
  logic [5:0]       tcp_hdr_q, tcp_hdr_d;
  logic [7:0]       proto_q, proto_d;
  logic [15:0]      total_q, total_d;
  logic [31:0]      src_ip_q, src_ip_d;
  logic [31:0]      dst_ip_q, dst_ip_d;
  logic [15:0]      src_port_q, src_port_d;
  logic [15:0]      dst_port_q, dst_port_d;
  logic [WinW-1:0]  window_q, window_d;
  logic [SeenW-1:0] seen_q, seen_d;
  logic             found_q, found_d;

  // Result queue: head entry drives the port, tail entry is the skid slot.
  summary_t    head_q, tail_q;
  logic [1:0]  count_q;

  logic        in_acc, push, pop;
  logic [7:0]  b;
  logic        take;
  logic [3:0]  klen;
  logic [15:0] hdr_end_d, hdr_end_q, pay_start;
  logic [5:0]  tl_q;
  logic signed [16:0] plen_q;
  logic        in_payload;
  logic        window_hit;
  logic [15:0] pay_pos;
  summary_t    summary;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign push          = in_acc && s_axis_tlast;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (count_q != 2'd2);
  assign cfg_ready_o   = 1'b1;
  assign b             = s_axis_tdata;

  // Bytes past the saturation point of the offset counter are ignored.
  assign take = in_acc && (byte_off_q != 16'hFFFF);
  assign klen = (key_len_q > KeyMax) ? KeyMax : key_len_q;

  // Field extraction. The IP header length takes effect for transport fields in the
  // same byte that carries it, so transport offsets use the updated value.
  always_comb begin
    ip_hdr_d   = ip_hdr_q;
    total_d    = total_q;
    proto_d    = proto_q;
    src_ip_d   = src_ip_q;
    dst_ip_d   = dst_ip_q;
    src_port_d = src_port_q;
    dst_port_d = dst_port_q;
    tcp_hdr_d  = tcp_hdr_q;
    if (take && byte_off_q == LinkOff) begin
      ip_hdr_d = {b[3:0], 2'b00};
    end
    hdr_end_d = LinkOff + {10'd0, ip_hdr_d};
    if (take) begin
      if (byte_off_q == LinkOff + 16'd2 || byte_off_q == LinkOff + 16'd3) begin
        total_d = {total_q[7:0], b};
      end
      if (byte_off_q == LinkOff + 16'd9) begin
        proto_d = b;
      end
      if (byte_off_q >= LinkOff + 16'd12 && byte_off_q <= LinkOff + 16'd15) begin
        src_ip_d = {src_ip_q[23:0], b};
      end
      if (byte_off_q >= LinkOff + 16'd16 && byte_off_q <= LinkOff + 16'd19) begin
        dst_ip_d = {dst_ip_q[23:0], b};
      end
      if (byte_off_q >= LinkOff) begin
        if (byte_off_q == hdr_end_d || byte_off_q == hdr_end_d + 16'd1) begin
          src_port_d = {src_port_q[7:0], b};
        end
        if (byte_off_q == hdr_end_d + 16'd2 || byte_off_q == hdr_end_d + 16'd3) begin
          dst_port_d = {dst_port_q[7:0], b};
        end
        if (byte_off_q == hdr_end_d + 16'd12) begin
          tcp_hdr_d = {b[7:4], 2'b00};
        end
      end
    end
  end

  // Payload gating. Inside the payload region every header field it depends on has
  // already arrived, so the stored values equal the updated ones.
  assign hdr_end_q = LinkOff + {10'd0, ip_hdr_q};
  assign tl_q      = transport_len(proto_q, tcp_hdr_q);
  assign pay_start = hdr_end_q + {10'd0, tl_q};
  assign plen_q    = payload_len(proto_q, total_q, ip_hdr_q, tcp_hdr_q);
  assign pay_pos   = byte_off_q - pay_start;

  always_comb begin
    in_payload = take
              && (byte_off_q > LinkOff + 16'd9)
              && !(proto_q == PROTO_TCP && byte_off_q <= hdr_end_q + 16'd12)
              && !plen_q[16] && (plen_q != '0)
              && (byte_off_q >= pay_start)
              && ({1'b0, pay_pos} < plen_q);
  end

  // Sliding window: the newest payload byte sits in bits 7:0, so window byte j is
  // compared with keyword byte klen-1-j.
  always_comb begin
    logic [3:0] idx;
    window_d   = window_q;
    seen_d     = seen_q;
    if (in_payload) begin
      window_d = (window_q << 8) | WinW'(b);
      if (seen_q < SeenMax) begin
        seen_d = seen_q + SeenW'(1);
      end
    end
    window_hit = 1'b1;
    for (int j = 0; j < KEY_MAX_BYTES; j++) begin
      idx = klen - 4'(j) - 4'd1;
      if (4'(j) < klen) begin
        if (window_d[8*j +: 8] != keyword_q[{idx[2:0], 3'b000} +: 8]) begin
          window_hit = 1'b0;
        end
      end
    end
    found_d = found_q
           || (in_payload && (klen != 4'd0) && (4'(seen_d) >= klen) && window_hit);
  end

  assign byte_off_d = take ? byte_off_q + 16'd1 : byte_off_q;

  // Summary of the frame, built from the state after its last byte.
  always_comb begin
    logic ports;
    summary.protocol_class  = classify(proto_d);
    ports                   = (summary.protocol_class == CLASS_TCP)
                           || (summary.protocol_class == CLASS_UDP);
    summary.source_address  = src_ip_d;
    summary.dest_address    = dst_ip_d;
    summary.source_port     = ports ? src_port_d : 16'd0;
    summary.dest_port       = ports ? dst_port_d : 16'd0;
    summary.ports_present   = ports;
    summary.ip_total_length = total_d;
    summary.payload_length  = payload_len(proto_d, total_d, ip_hdr_d, tcp_hdr_d);
    summary.keyword_found   = (klen != 4'd0) && found_d;
    summary.frame_accepted  = (klen == 4'd0)
                           || (!summary.payload_length[16]
                               && (summary.payload_length != '0) && found_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keyword_q <= '0;
      key_len_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_KEYWORD_BYTES:  keyword_q <= cfg_data_i;
        CFG_KEYWORD_LENGTH: key_len_q <= cfg_data_i[3:0];
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_off_q <= '0;
      ip_hdr_q   <= '0;
      tcp_hdr_q  <= '0;
      proto_q    <= '0;
      total_q    <= '0;
      src_ip_q   <= '0;
      dst_ip_q   <= '0;
      src_port_q <= '0;
      dst_port_q <= '0;
      window_q   <= '0;
      seen_q     <= '0;
      found_q    <= 1'b0;
    end else if (push) begin
      // The summary has been captured; start the next frame from scratch.
      byte_off_q <= '0;
      ip_hdr_q   <= '0;
      tcp_hdr_q  <= '0;
      proto_q    <= '0;
      total_q    <= '0;
      src_ip_q   <= '0;
      dst_ip_q   <= '0;
      src_port_q <= '0;
      dst_port_q <= '0;
      window_q   <= '0;
      seen_q     <= '0;
      found_q    <= 1'b0;
    end else begin
      byte_off_q <= byte_off_d;
      ip_hdr_q   <= ip_hdr_d;
      tcp_hdr_q  <= tcp_hdr_d;
      proto_q    <= proto_d;
      total_q    <= total_d;
      src_ip_q   <= src_ip_d;
      dst_ip_q   <= dst_ip_d;
      src_port_q <= src_port_d;
      dst_port_q <= dst_port_d;
      window_q   <= window_d;
      seen_q     <= seen_d;
      found_q    <= found_d;
    end
  end

  // Result queue control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (push && !pop) begin
      count_q <= count_q + 2'd1;
    end else if (pop && !push) begin
      count_q <= count_q - 2'd1;
    end
  end

  // Result queue payload.
  always_ff @(posedge clk_i) begin
    if (push && !pop) begin
      if (count_q == 2'd0) begin
        head_q <= summary;
      end else begin
        tail_q <= summary;
      end
    end else if (pop && !push) begin
      head_q <= tail_q;
    end else if (push && pop) begin
      if (count_q == 2'd1) begin
        head_q <= summary;
      end else begin
        head_q <= tail_q;
        tail_q <= summary;
      end
    end
  end

  assign m_axis_tvalid = (count_q != 2'd0);
  assign m_axis_tuser  = head_q.protocol_class;
  assign m_axis_tdata  = {4'd0,
                          head_q.frame_accepted,
                          head_q.keyword_found,
                          head_q.payload_length,
                          head_q.ip_total_length,
                          head_q.ports_present,
                          head_q.dest_port,
                          head_q.source_port,
                          head_q.dest_address,
                          head_q.source_address};

  `PHCK_ASSERT_ALWAYS(a_queue_bound, count_q != 2'd3, "result queue count out of range")
  `PHCK_ASSERT(a_queue_grow, (push && !pop) |=> count_q == $past(count_q) + 2'd1,
               "result queue did not grow on a lone push")
  `PHCK_ASSERT(a_frame_clear, push |=> (byte_off_q == 16'd0 && !found_q && seen_q == '0),
               "per-frame state not cleared after a summary")
  `PHCK_ASSERT(a_found_needs_key, (found_d && !found_q) |-> (klen != 4'd0 && in_payload),
               "keyword match flagged outside the payload or with no keyword")
  `PHCK_ASSERT_ALWAYS(a_seen_bound, seen_q <= SeenMax, "payload byte count above window size")

endmodule

// ----- bench/packet_header_classifier_keyword_check.sv -----
`timescale 1ns / 1ps
// Scoreboard for the packet header classifier: it follows the byte, summary and
// configuration channels, predicts every frame summary and compares it on arrival.
// Depends on phck_pkg for the summary layout, protocol numbers and register indexes.

module packet_header_classifier_keyword_check #(
  parameter int KEY_MAX_BYTES     = 8,
  parameter int LINK_HEADER_BYTES = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  input  logic                   s_axis_tready_i,
  input  logic [7:0]             s_axis_tdata_i,
  input  logic                   s_axis_tlast_i,
  input  logic                   m_axis_tvalid_i,
  input  logic                   m_axis_tready_i,
  input  logic [135:0]           m_axis_tdata_i,
  input  phck_pkg::proto_class_e m_axis_tuser_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  phck_pkg::cfg_index_e   cfg_index_i,
  input  logic [63:0]            cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);
  import phck_pkg::*;

  // Keyword registers as the block should hold them.
  logic [63:0] key_bytes_r;
  logic [3:0]  key_len_r;

  // Per-frame parser state.
  logic [15:0] offset_r;
  logic [5:0]  ip_hdr_r;
  logic [5:0]  tcp_hdr_r;
  logic [7:0]  proto_r;
  logic [15:0] total_r;
  logic [31:0] src_ip_r;
  logic [31:0] dst_ip_r;
  logic [15:0] src_port_r;
  logic [15:0] dst_port_r;
  logic [63:0] window_r;
  logic [3:0]  seen_r;
  logic        hit_r;

  summary_t summary_q[$];
  summary_t got;
  summary_t want;
  int       mismatches;

  task automatic clear_frame_state();
    offset_r   = '0;
    ip_hdr_r   = '0;
    tcp_hdr_r  = '0;
    proto_r    = '0;
    total_r    = '0;
    src_ip_r   = '0;
    dst_ip_r   = '0;
    src_port_r = '0;
    dst_port_r = '0;
    window_r   = '0;
    seen_r     = '0;
    hit_r      = 1'b0;
  endtask

  function automatic int key_used();
    return (key_len_r > KEY_MAX_BYTES) ? KEY_MAX_BYTES : int'(key_len_r);
  endfunction

  function automatic int transport_bytes();
    return (proto_r == PROTO_TCP) ? int'(tcp_hdr_r) : int'(FIXED_TRANSPORT_BYTES);
  endfunction

  function automatic int frame_payload_len();
    int diff;
    if (proto_r != PROTO_TCP && proto_r != PROTO_UDP && proto_r != PROTO_ICMP) begin
      return -1;
    end
    diff = int'(total_r) - int'(ip_hdr_r) - transport_bytes();
    return (diff < 0) ? -1 : diff;
  endfunction

  // The oldest window byte lines up with the first keyword byte.
  function automatic logic window_hit(input int klen);
    for (int i = 0; i < klen; i++) begin
      if (window_r[8 * (klen - 1 - i) +: 8] != key_bytes_r[8 * i +: 8]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic absorb_byte(input logic [7:0] b);
    int o;
    int t;
    int plen;
    int start;
    int klen;
    o = int'(offset_r);
    if (o == LINK_HEADER_BYTES) ip_hdr_r = {b[3:0], 2'b00};
    if (o == LINK_HEADER_BYTES + 2 || o == LINK_HEADER_BYTES + 3) begin
      total_r = {total_r[7:0], b};
    end
    if (o == LINK_HEADER_BYTES + 9) proto_r = b;
    if (o >= LINK_HEADER_BYTES + 12 && o <= LINK_HEADER_BYTES + 15) begin
      src_ip_r = {src_ip_r[23:0], b};
    end
    if (o >= LINK_HEADER_BYTES + 16 && o <= LINK_HEADER_BYTES + 19) begin
      dst_ip_r = {dst_ip_r[23:0], b};
    end
    if (o < LINK_HEADER_BYTES) return;

    // Transport fields are placed by the header length known so far, so they may
    // share bytes with IP fields when the header length is small.
    t = LINK_HEADER_BYTES + int'(ip_hdr_r);
    if (o == t || o == t + 1) src_port_r = {src_port_r[7:0], b};
    if (o == t + 2 || o == t + 3) dst_port_r = {dst_port_r[7:0], b};
    if (o == t + 12) tcp_hdr_r = {b[7:4], 2'b00};

    // Payload only counts once the protocol and, for TCP, the data offset are in.
    if (o <= LINK_HEADER_BYTES + 9) return;
    if (proto_r == PROTO_TCP && o <= t + 12) return;
    plen  = frame_payload_len();
    start = t + transport_bytes();
    if (plen <= 0 || o < start) return;
    if (o - start >= plen) return;
    window_r = {window_r[55:0], b};
    if (seen_r < KEY_MAX_BYTES) seen_r = seen_r + 4'd1;
    klen = key_used();
    if (klen > 0 && int'(seen_r) >= klen && window_hit(klen)) hit_r = 1'b1;
  endtask

  task automatic predict_summary();
    summary_t s;
    logic     ports;
    int       plen;
    if (proto_r == PROTO_TCP)       s.protocol_class = CLASS_TCP;
    else if (proto_r == PROTO_UDP)  s.protocol_class = CLASS_UDP;
    else if (proto_r == PROTO_ICMP) s.protocol_class = CLASS_ICMP;
    else                            s.protocol_class = CLASS_OTHER;
    ports             = (proto_r == PROTO_TCP) || (proto_r == PROTO_UDP);
    plen              = frame_payload_len();
    s.source_address  = src_ip_r;
    s.dest_address    = dst_ip_r;
    s.source_port     = ports ? src_port_r : 16'd0;
    s.dest_port       = ports ? dst_port_r : 16'd0;
    s.ports_present   = ports;
    s.ip_total_length = total_r;
    s.payload_length  = plen[16:0];
    s.keyword_found   = (key_used() > 0) && hit_r;
    s.frame_accepted  = (key_used() == 0) || (plen > 0 && hit_r);
    summary_q.push_back(s);
  endtask

  function automatic string show(input summary_t s);
    return {$sformatf("class=%0d src=%h dst=%h sport=%h dport=%h ports=%b ",
                      s.protocol_class, s.source_address, s.dest_address, s.source_port,
                      s.dest_port, s.ports_present),
            $sformatf("total=%h payload=%h found=%b accepted=%b",
                      s.ip_total_length, s.payload_length, s.keyword_found,
                      s.frame_accepted)};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_bytes_r = '0;
      key_len_r   = '0;
      clear_frame_state();
      summary_q.delete();
      mismatches   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // A summary can never belong to a byte taken at the same edge, so it is
      // matched against the queue before this edge's byte is predicted.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.protocol_class  = m_axis_tuser_i;
        got.source_address  = m_axis_tdata_i[31:0];
        got.dest_address    = m_axis_tdata_i[63:32];
        got.source_port     = m_axis_tdata_i[79:64];
        got.dest_port       = m_axis_tdata_i[95:80];
        got.ports_present   = m_axis_tdata_i[96];
        got.ip_total_length = m_axis_tdata_i[112:97];
        got.payload_length  = m_axis_tdata_i[129:113];
        got.keyword_found   = m_axis_tdata_i[130];
        got.frame_accepted  = m_axis_tdata_i[131];
        if (summary_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected summary: %s", show(got));
        end else begin
          want = summary_q.pop_front();
          if (got !== want || m_axis_tdata_i[135:132] !== 4'd0) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("summary mismatch:\n  expected %s\n  actual   %s pad=%h",
                       show(want), show(got), m_axis_tdata_i[135:132]);
            end
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_KEYWORD_BYTES) key_bytes_r = cfg_data_i;
        else                                  key_len_r   = cfg_data_i[3:0];
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (offset_r != 16'hFFFF) begin
          absorb_byte(s_axis_tdata_i);
          offset_r = offset_r + 16'd1;
        end
        if (s_axis_tlast_i) begin
          predict_summary();
          clear_frame_state();
        end
      end

      fail_count_o <= mismatches;
      pending_o    <= summary_q.size();
    end
  end

endmodule

// ----- bench/packet_header_classifier_keyword_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the packet header classifier: builds IPv4 frames and noise,
// drives the byte and configuration channels and gives the verdict.
// Depends on phck_pkg, the classifier RTL and packet_header_classifier_keyword_check.

module packet_header_classifier_keyword_test;
  import phck_pkg::*;

  localparam int LINK          = 14;
  // Extra idle time once every predicted summary has come out.
  localparam int SETTLE_CYCLES = 8;
  // The slowest correct run stays far below this.
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_BYTES  = 1200;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid  = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata   = 8'd0;
  logic                   s_axis_tlast   = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready  = 1'b0;
  logic [135:0]           m_axis_tdata;
  proto_class_e           m_axis_tuser;
  logic                   cfg_valid      = 1'b0;
  logic                   cfg_ready;
  cfg_index_e             cfg_index      = CFG_KEYWORD_BYTES;
  logic [63:0]            cfg_data       = 64'd0;

  int                     fail_count;
  int                     pending;
  int                     cycles         = 0;

  // When set, both sides run without gaps.
  logic                   no_idle        = 1'b0;
  // The keyword as last written, used to plant it in payloads.
  logic [63:0]            key_cur        = 64'd0;
  logic [3:0]             key_len_cur    = 4'd0;
  logic [7:0]             frame_q[$];
  int                     random_bytes   = 0;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  packet_header_classifier_keyword u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  packet_header_classifier_keyword_check u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("packet_header_classifier_keyword_test NOT OK");
      $finish;
    end
  end

  // Summary receiver. Before each summary it holds tready low for a random number
  // of cycles; with a gap of zero tready simply stays high across summaries.
  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Sends one frame byte. Every task here is entered and left at a rising edge,
  // and the handshake is judged on the values from before that edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) begin
      send_byte(frame_q[i], i == frame_q.size() - 1);
    end
    random_bytes  += frame_q.size();
  endtask

  // Waits until every predicted summary has come out and the block has settled.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Writes both keyword registers while the block is idle. The length register
  // also gets random upper data bits, which the block must ignore.
  task automatic set_keyword(input logic [63:0] kb, input logic [3:0] len);
    logic [63:0] junk;
    quiesce();
    junk = {$urandom, $urandom};
    write_reg(CFG_KEYWORD_BYTES, kb);
    write_reg(CFG_KEYWORD_LENGTH, {junk[63:4], len});
    cfg_valid   <= 1'b0;
    key_cur     = kb;
    key_len_cur = len;
  endtask

  function automatic void poke(input int pos, input logic [7:0] v);
    if (pos < frame_q.size()) frame_q[pos] = v;
  endfunction

  // Builds an Ethernet/IPv4 frame with random content. A negative total_len takes
  // the consistent total length, a negative frame_len the natural frame size, and
  // a non-negative key_pos plants the keyword at that payload offset. Transport
  // fields go in first, so IP fields win where the two overlap.
  task automatic build_ip_frame(input int ihl, input int proto, input int doff,
                                input int pay_len, input int total_len,
                                input int frame_len, input int key_pos);
    int ip_bytes;
    int tp_bytes;
    int tp_at;
    int pay_at;
    int total;
    int n;
    int klen;
    ip_bytes = ihl * 4;
    tp_bytes = (proto == PROTO_TCP) ? doff * 4 : 8;
    tp_at    = LINK + ip_bytes;
    pay_at   = tp_at + tp_bytes;
    n        = (frame_len < 0) ? pay_at + pay_len : frame_len;
    total    = (total_len < 0) ? ip_bytes + tp_bytes + pay_len : total_len;
    frame_q.delete();
    repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
    poke(tp_at + 12, 8'(doff * 16 + $urandom_range(0, 15)));
    poke(LINK, 8'(8'h40 + ihl));
    poke(LINK + 2, total[15:8]);
    poke(LINK + 3, total[7:0]);
    poke(LINK + 9, 8'(proto));
    klen = (key_len_cur > 8) ? 8 : int'(key_len_cur);
    if (key_pos >= 0) begin
      for (int i = 0; i < klen; i++) poke(pay_at + key_pos + i, key_cur[8 * i +: 8]);
    end
  endtask

  task automatic constant_frame(input int n, input logic [7:0] v);
    frame_q.delete();
    repeat (n) frame_q.push_back(v);
  endtask

  // Mostly well-formed frames with random fields; the rest is raw noise.
  task automatic random_frame();
    int ihl;
    int proto;
    int doff;
    int pay;
    int total;
    int natural;
    int flen;
    int kpos;
    int sel;
    if ($urandom_range(0, 4) == 0) begin
      frame_q.delete();
      repeat ($urandom_range(1, 60)) frame_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      ihl  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 5;
      sel  = $urandom_range(0, 19);
      if (sel < 7)       proto = int'(PROTO_TCP);
      else if (sel < 13) proto = int'(PROTO_UDP);
      else if (sel < 16) proto = int'(PROTO_ICMP);
      else               proto = $urandom_range(0, 255);
      doff = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 5;
      pay  = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 32);
      sel  = $urandom_range(0, 15);
      if (sel == 0)      total = $urandom_range(0, 65535);
      else if (sel < 3)  total = $urandom_range(0, 80);
      else               total = -1;
      natural = LINK + ihl * 4 + ((proto == PROTO_TCP) ? doff * 4 : 8) + pay;
      sel  = $urandom_range(0, 7);
      if (sel == 0)      flen = $urandom_range(1, natural);
      else if (sel == 1) flen = natural + $urandom_range(1, 8);
      else               flen = -1;
      kpos = ($urandom_range(0, 1) == 0) ? $urandom_range(0, pay + 2) : -1;
      build_ip_frame(ihl, proto, doff, pay, total, flen, kpos);
    end
  endtask

  task automatic random_keyword();
    logic [63:0] kb;
    logic [3:0]  len;
    case ($urandom_range(0, 4))
      0:       len = 4'd0;
      1:       len = 4'd1;
      2:       len = 4'd8;
      3:       len = 4'd15;
      default: len = 4'($urandom_range(2, 7));
    endcase
    case ($urandom_range(0, 3))
      0:       kb = 64'd0;
      1:       kb = '1;
      default: kb = {$urandom, $urandom};
    endcase
    set_keyword(kb, len);
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames. The first ones run on the reset keyword, which disables
    // filtering, so every frame is accepted whatever its payload.
    build_ip_frame(5, PROTO_TCP, 5, 10, -1, -1, -1);
    send_frame();
    // Short frames: a lone byte, then a frame that stops inside the IP header.
    build_ip_frame(5, PROTO_TCP, 5, 10, -1, 1, -1);
    send_frame();
    build_ip_frame(5, PROTO_TCP, 5, 10, -1, 20, -1);
    send_frame();

    set_keyword({$urandom, $urandom}, 4'd4);
    // Keyword inside a TCP payload, absent from a UDP one, flush with the end of an ICMP
    // payload, and placed beyond the end of a UDP frame that is cut short in its payload.
    build_ip_frame(5, PROTO_TCP, 5, 16, -1, -1, 3);
    send_frame();
    build_ip_frame(5, PROTO_UDP, 5, 12, -1, -1, -1);
    send_frame();
    build_ip_frame(5, PROTO_ICMP, 5, 8, -1, -1, 4);
    send_frame();
    build_ip_frame(5, PROTO_UDP, 5, 8, -1, 44, 5);
    send_frame();
    // Unknown protocol: no payload, so the keyword cannot pass the frame.
    build_ip_frame(5, 255, 5, 8, -1, -1, 2);
    send_frame();
    // Zero header length: ports overlap the IP header and the payload would
    // begin before the protocol byte, so the planted keyword is cut short.
    build_ip_frame(0, PROTO_UDP, 5, 12, -1, -1, 0);
    send_frame();
    // Small header length with a zero TCP data offset: payload starts only after
    // the data offset byte.
    build_ip_frame(1, PROTO_TCP, 0, 20, -1, -1, 14);
    send_frame();
    // Total length below the headers gives a negative payload size.
    build_ip_frame(5, PROTO_TCP, 5, 10, 4, -1, 0);
    send_frame();
    // Field extremes: every byte all ones, then every byte zero.
    constant_frame(60, 8'hFF);
    send_frame();
    constant_frame(60, 8'h00);
    send_frame();

    // An all-zero keyword of maximum length must match zero bytes like any other.
    set_keyword(64'd0, 4'd8);
    build_ip_frame(5, PROTO_UDP, 5, 20, -1, -1, 6);
    send_frame();

    // A length above the maximum acts as the maximum; largest header sizes too.
    set_keyword('1, 4'd15);
    build_ip_frame(15, PROTO_TCP, 15, 10, -1, -1, 1);
    send_frame();

    // Random phases, each under a fresh keyword setting and idling mode.
    random_bytes  = 0;
    while (random_bytes < RANDOM_BYTES) begin
      random_keyword();
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(6, 10)) begin
        random_frame();
        send_frame();
      end
    end

    quiesce();
    if (fail_count == 0) begin
      $display("packet_header_classifier_keyword_test OK");
    end else begin
      $display("packet_header_classifier_keyword_test NOT OK");
    end
    $finish;
  end

endmodule
